// ===== rtl/fsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_pkg
// Shared widths, constants and the rounding multiply of the Fresnel core.
// ----------------------------------------------------------------------------
package fsr_pkg;

	// Port field widths
	localparam int VecW  = 16;              // Q2.14 vector component
	localparam int IdxW  = 16;              // Q2.14 refractive index
	localparam int FracW = 16;              // Q1.15 reflectance

	// Internal widths
	localparam int DotW     = 33;           // cosine in Q.28, signed
	localparam int CosShift = 13;           // Q.28 down to Q.15
	localparam int CosW     = DotW - CosShift;
	localparam int NumW     = 50;           // r0 dividend
	localparam int DenW     = 34;           // (k1 + k2)^2
	localparam int QuoW     = 16;           // r0 quotient, at most 1.0
	localparam int PowW     = 15;           // powers of (1 - cos), below 1.0
	localparam int SqW      = 30;           // cos^2 when |cos| < 1.0
	localparam int SW       = SqW + 1;      // 1 - cos^2 in Q.30
	localparam int ProdW    = 2 * IdxW + SW; // k1^2 * (1 - cos^2)

	// Fixed point constants
	localparam logic [FracW-1:0] OneQ15  = 16'h8000;
	localparam logic [31:0]      HalfQ15 = 32'h0000_4000;

	// Q.15 product rounded half up
	function automatic logic [FracW-1:0] mul_q15(input logic [FracW-1:0] a,
		input logic [PowW-1:0] b);
		logic [31:0] prod;
		prod = (32'(a) * 32'(b)) + HalfQ15;
		return prod[30:15];
	endfunction

endpackage

// ===== rtl/fresnel_schlick_reflectance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_schlick_reflectance_core
// Schlick Fresnel reflectance with total internal reflection detection.
// ----------------------------------------------------------------------------
// Usage:
// Input channel (in_valid / in_ready) carries one hit: incident direction and
// surface normal in signed Q2.14, indices of both media in unsigned Q2.14.
// Output channel (out_valid / out_ready) returns one item per hit: the
// reflected fraction in Q1.15 (at most 1.0) and the total internal flag.
// Items leave in the order they entered.
// One item per cycle is sustained while out_ready stays high. The pipeline
// depth is set by the 16-stage r0 divider, one quotient bit per stage,
// plus the dot product and the final blend.
// Reset clears every valid bit; in_ready is high right after reset.
// When the receiver stalls, the output register holds its item and one more
// item is caught in a skid register; only then in_ready drops and the whole
// pipeline holds until the output is taken.
module fresnel_schlick_reflectance_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [fsr_pkg::VecW-1:0] incident_x,
	input  logic signed [fsr_pkg::VecW-1:0] incident_y,
	input  logic signed [fsr_pkg::VecW-1:0] incident_z,
	input  logic signed [fsr_pkg::VecW-1:0] normal_x,
	input  logic signed [fsr_pkg::VecW-1:0] normal_y,
	input  logic signed [fsr_pkg::VecW-1:0] normal_z,
	input  logic [fsr_pkg::IdxW-1:0]      index_from,
	input  logic [fsr_pkg::IdxW-1:0]      index_to,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [fsr_pkg::FracW-1:0]     reflect_fraction,
	output logic                          total_internal
);
	import fsr_pkg::*;

	localparam int PipeLen = 21;            // stages up to the final result
	localparam int SideLen = 11;            // carry from stage 9 to stage 19

	localparam logic signed [CosW-1:0] CosOne    = CosW'(OneQ15);
	localparam logic signed [CosW-1:0] CosNegOne = -CosOne;
	localparam logic signed [CosW-1:0] CosZero   = '0;

	typedef struct packed {
		logic            tir;
		logic            sat;
		logic            zsum;
		logic [PowW-1:0] p;
	} side_t;

	logic              en;
	logic [PipeLen:1]  vld_s;

	// Stage 1: products and index sums
	logic signed [31:0] pxx_s1, pyy_s1, pzz_s1;
	logic [IdxW:0]      sum_s1;
	logic [IdxW-1:0]    diff_s1, k1_s1, k2_s1;
	logic               k1gt_s1;

	// Stage 2: cosine in Q.28, squares
	logic signed [DotW:0]   dot_sum, cos_full;
	logic signed [DotW-1:0] cos28_s2;
	logic [2*IdxW-1:0]      diffsq_s2, k1sq_s2, k2sq_s2;
	logic [DenW-1:0]        den_s2;
	logic                   k1gt_s2, zsum_s2;

	// Stage 3: cosine in Q.15, divider operands
	logic signed [CosW-1:0] cq_s3;
	logic [NumW-1:0]        num_s3;
	logic [DenW-1:0]        den_s3;
	logic [2*IdxW-1:0]      k1sq_s3, k2sq_s3;
	logic                   k1gt_s3, zsum_s3;

	// Stage 4: cos^2, x = 1 - cos
	logic                   inrange;
	logic signed [15:0]     cq16;
	logic signed [31:0]     cq_sq_full;
	logic signed [CosW-1:0] ux_full;
	logic                   sat_c;
	logic [SqW-1:0]         cqsq_s4;
	logic [PowW-1:0]        ux_s4;
	logic [2*IdxW-1:0]      k1sq_s4, k2sq_s4;
	logic                   tirok_s4, sat_s4, zsum_s4;

	// Stages 5 to 8: total internal test and x^5
	logic [SW-1:0]          s_s5;
	logic [PowW-1:0]        p2_s5, ux_s5;
	logic [2*IdxW-1:0]      k1sq_s5, k2sq_s5;
	logic                   tirok_s5, sat_s5, zsum_s5;

	logic [ProdW-1:0]       tprod_s6;
	logic [PowW-1:0]        p3_s6, ux_s6;
	logic [2*IdxW-1:0]      k2sq_s6;
	logic                   tirok_s6, sat_s6, zsum_s6;

	logic [PowW-1:0]        p4_s7, ux_s7;
	logic                   tir_s7, sat_s7, zsum_s7;

	side_t                  side_s8;
	side_t                  side_s [SideLen];

	// Stages 20 and 21: blend and saturate
	logic [QuoW-1:0]        quo;
	logic [FracW-1:0]       r0, omr;
	logic [FracW-1:0]       r0_s20, m_s20;
	logic                   force_s20, tir_s20;
	logic [FracW:0]         blend;
	logic [FracW-1:0]       res_s21;
	logic                   tir_s21;

	// Output register and skid
	logic                   out_vld_q, skid_vld_q;
	logic [FracW-1:0]       out_res_q, skid_res_q;
	logic                   out_tir_q, skid_tir_q;
	logic                   out_take;

	// Advance the pipeline whenever the skid register is free
	assign en       = !skid_vld_q;
	assign in_ready = en;
	assign out_take = !out_vld_q || out_ready;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[PipeLen-1:1], in_valid};
		end
	end

	// Combinational helpers
	assign dot_sum = $signed({{2{pxx_s1[31]}}, pxx_s1}) + $signed({{2{pyy_s1[31]}}, pyy_s1})
		+ $signed({{2{pzz_s1[31]}}, pzz_s1});
	assign cos_full = -dot_sum;

	assign inrange    = (cq_s3 > CosNegOne) && (cq_s3 < CosOne);
	assign cq16       = cq_s3[15:0];
	assign cq_sq_full = cq16 * cq16;
	assign ux_full    = CosOne - cq_s3;
	assign sat_c      = (cq_s3 <= CosZero);

	assign r0    = side_s[SideLen-1].zsum ? '0 : quo;
	assign omr   = OneQ15 - r0;
	assign blend = {1'b0, r0_s20} + {1'b0, m_s20};

	// Pipeline payload, held while stalled
	always_ff @(posedge clk) begin
		if (en) begin
			// stage 1
			pxx_s1  <= incident_x * normal_x;
			pyy_s1  <= incident_y * normal_y;
			pzz_s1  <= incident_z * normal_z;
			sum_s1  <= {1'b0, index_from} + {1'b0, index_to};
			diff_s1 <= (index_from >= index_to) ? (index_from - index_to)
				: (index_to - index_from);
			k1_s1   <= index_from;
			k2_s1   <= index_to;
			k1gt_s1 <= (index_from > index_to);

			// stage 2
			cos28_s2  <= cos_full[DotW-1:0];
			diffsq_s2 <= diff_s1 * diff_s1;
			den_s2    <= sum_s1 * sum_s1;
			k1sq_s2   <= k1_s1 * k1_s1;
			k2sq_s2   <= k2_s1 * k2_s1;
			k1gt_s2   <= k1gt_s1;
			zsum_s2   <= (sum_s1 == '0);

			// stage 3: floor to Q.15, round-half-up dividend for r0
			cq_s3   <= cos28_s2[DotW-1:CosShift];
			num_s3  <= {3'b000, diffsq_s2, 15'b0} + {17'b0, den_s2[DenW-1:1]};
			den_s3  <= den_s2;
			k1sq_s3 <= k1sq_s2;
			k2sq_s3 <= k2sq_s2;
			k1gt_s3 <= k1gt_s2;
			zsum_s3 <= zsum_s2;

			// stage 4
			cqsq_s4  <= cq_sq_full[SqW-1:0];
			ux_s4    <= (sat_c || (cq_s3 >= CosOne)) ? '0 : ux_full[PowW-1:0];
			k1sq_s4  <= k1sq_s3;
			k2sq_s4  <= k2sq_s3;
			tirok_s4 <= k1gt_s3 && inrange;
			sat_s4   <= sat_c;
			zsum_s4  <= zsum_s3;

			// stage 5
			s_s5     <= {1'b1, {SqW{1'b0}}} - {1'b0, cqsq_s4};
			p2_s5    <= PowW'(mul_q15({1'b0, ux_s4}, ux_s4));
			ux_s5    <= ux_s4;
			k1sq_s5  <= k1sq_s4;
			k2sq_s5  <= k2sq_s4;
			tirok_s5 <= tirok_s4;
			sat_s5   <= sat_s4;
			zsum_s5  <= zsum_s4;

			// stage 6
			tprod_s6 <= k1sq_s5 * s_s5;
			p3_s6    <= PowW'(mul_q15({1'b0, p2_s5}, ux_s5));
			ux_s6    <= ux_s5;
			k2sq_s6  <= k2sq_s5;
			tirok_s6 <= tirok_s5;
			sat_s6   <= sat_s5;
			zsum_s6  <= zsum_s5;

			// stage 7: total internal reflection decision
			tir_s7  <= tirok_s6 && (tprod_s6 > {1'b0, k2sq_s6, {SqW{1'b0}}});
			p4_s7   <= PowW'(mul_q15({1'b0, p3_s6}, ux_s6));
			ux_s7   <= ux_s6;
			sat_s7  <= sat_s6;
			zsum_s7 <= zsum_s6;

			// stage 8
			side_s8.tir  <= tir_s7;
			side_s8.sat  <= sat_s7;
			side_s8.zsum <= zsum_s7;
			side_s8.p    <= PowW'(mul_q15({1'b0, p4_s7}, ux_s7));

			// stages 9 to 19: wait for the divider
			side_s[0] <= side_s8;
			for (int i = 1; i < SideLen; i++) begin
				side_s[i] <= side_s[i-1];
			end

			// stage 20
			r0_s20    <= r0;
			m_s20     <= mul_q15(omr, side_s[SideLen-1].p);
			force_s20 <= side_s[SideLen-1].tir || side_s[SideLen-1].sat;
			tir_s20   <= side_s[SideLen-1].tir;

			// stage 21
			if (force_s20 || (blend > {1'b0, OneQ15})) begin
				res_s21 <= OneQ15;
			end else begin
				res_s21 <= blend[FracW-1:0];
			end
			tir_s21 <= tir_s20;
		end
	end

	// r0 divider, stages 4 to 19
	fsr_div u_div (
		.clk (clk),
		.en  (en),
		.num (num_s3),
		.den (den_s3),
		.quo (quo)
	);

	// Output register and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_take) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= vld_s[PipeLen];
			end
		end else if (en && vld_s[PipeLen]) begin
			skid_vld_q <= 1'b1;
		end
	end

	// Output and skid payload
	always_ff @(posedge clk) begin
		if (out_take) begin
			out_res_q <= skid_vld_q ? skid_res_q : res_s21;
			out_tir_q <= skid_vld_q ? skid_tir_q : tir_s21;
		end else if (en && vld_s[PipeLen]) begin
			skid_res_q <= res_s21;
			skid_tir_q <= tir_s21;
		end
	end

	assign out_valid        = out_vld_q;
	assign reflect_fraction = out_res_q;
	assign total_internal   = out_tir_q;

endmodule

// ===== rtl/fsr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_div
// Pipelined restoring divider for r0: one quotient bit per stage, advancing
// together with the rest of the core on a shared enable.
// ----------------------------------------------------------------------------
module fsr_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [fsr_pkg::NumW-1:0]   num,
	input  logic [fsr_pkg::DenW-1:0]   den,
	output logic [fsr_pkg::QuoW-1:0]   quo
);
	import fsr_pkg::*;

	// Partial remainder and divisor travel only as far as the last step needs them
	logic [NumW-1:0] rem_s [QuoW-1];
	logic [DenW-1:0] den_s [QuoW-1];
	logic [QuoW-1:0] quo_s [QuoW];

	for (genvar k = 0; k < QuoW; k++) begin : g_step
		localparam int Bit = QuoW - 1 - k;
		logic [NumW-1:0] rem_in;
		logic [DenW-1:0] den_in;
		logic [QuoW-1:0] quo_in;
		logic [NumW-1:0] dsh;
		logic            ge;

		if (k == 0) begin : g_first
			assign rem_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		// Trial subtract of the divisor at this bit weight
		assign dsh = NumW'(den_in) << Bit;
		assign ge  = (rem_in >= dsh);

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k] <= quo_in | (QuoW'(ge) << Bit);
			end
		end

		if (k < QuoW - 1) begin : g_keep
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? (rem_in - dsh) : rem_in;
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign quo = quo_s[QuoW-1];

endmodule

// ===== rtl/fsr_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsr_chk
// Port-level checks for the Fresnel core, bound to its top level.
// ----------------------------------------------------------------------------
module fsr_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [fsr_pkg::FracW-1:0]   reflect_fraction,
	input logic                        total_internal
);
	import fsr_pkg::*;

	// Total internal reflection always reports full reflectance
	a_tir_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_internal |-> reflect_fraction == OneQ15)
		else $error("total internal item without full reflectance");

	// Reflectance never exceeds 1.0
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reflect_fraction <= OneQ15)
		else $error("reflectance above 1.0");

	// A stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reflect_fraction)
			&& $stable(total_internal))
		else $error("stalled output item changed");

	// Input backpressure only comes from a held output item
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind fresnel_schlick_reflectance_core fsr_chk u_fsr_chk (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Schlick Fresnel reflectance core. A short table
// of hits covers normal and grazing incidence, cosines at and beyond one in
// magnitude, total internal reflection near the critical angle and the index
// extremes. Random hits follow, mostly built around axis-aligned unit
// normals so that the cosine sweeps the whole range. Each accepted hit is
// predicted here in fixed point unless the table gives its item, and every
// returned item is compared field by field in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
	import fsr_pkg::*;

	localparam int     RESET_CYCLES = 11;
	localparam int     RANDOM_ITEMS = 1850;
	localparam int     BURST_LO     = 500;    // stretch with no sender gaps
	localparam int     BURST_HI     = 700;
	localparam int     DRAIN_AT     = 1000;   // sender waits for every result
	localparam int     SETTLE       = 40;     // cycles after the last result
	localparam int     IDLE_LIMIT   = 2000;   // cycles with no handshake at all
	localparam longint UNIT         = 64'sd32768;
	localparam longint HALF         = 64'sd16384;
	localparam bit     PRESET       = 1'b1;   // expectation typed into the table
	localparam bit     CALC         = 1'b0;   // expectation from the predictor

	typedef struct packed {
		logic signed [VecW-1:0] ix, iy, iz;
		logic signed [VecW-1:0] nx, ny, nz;
		logic [IdxW-1:0]        kf, kt;
	} hit_t;

	typedef struct packed {
		logic [FracW-1:0] frac;
		logic             tir;
	} shade_t;

	typedef struct packed {
		hit_t   hit;
		logic   preset;
		shade_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [VecW-1:0] incident_x = '0, incident_y = '0, incident_z = '0;
	logic signed [VecW-1:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic [IdxW-1:0] index_from = 16'h4000, index_to = 16'h4000;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [FracW-1:0] reflect_fraction;
	logic total_internal;

	shade_t   reflect_due_q[$];
	dir_row_t dir_table[$];
	int       mismatch_count = 0;
	int       ready_hold = 0;
	int       idle_cycles = 0;

	fresnel_schlick_reflectance_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.incident_x(incident_x),
		.incident_y(incident_y),
		.incident_z(incident_z),
		.normal_x(normal_x),
		.normal_y(normal_y),
		.normal_z(normal_z),
		.index_from(index_from),
		.index_to(index_to),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.reflect_fraction(reflect_fraction),
		.total_internal(total_internal)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Q.15 product, rounded half up
	function automatic longint round_q15(longint a, longint b);
		return (a * b + HALF) >>> 15;
	endfunction

	// Predict reflectance and the total internal flag of one hit
	function automatic shade_t schlick_reflectance(hit_t h);
		longint cos28, cq, k1, k2, sum, diff, den, r0, s, x, ux, p, res;
		shade_t o;
		cos28 = -(longint'(h.ix) * longint'(h.nx) + longint'(h.iy) * longint'(h.ny)
			+ longint'(h.iz) * longint'(h.nz));
		// floor toward minus infinity, Q.28 down to Q.15
		cq = cos28 >>> 13;
		k1 = longint'(64'(h.kf));
		k2 = longint'(64'(h.kt));
		sum = k1 + k2;
		diff = (k1 >= k2) ? k1 - k2 : k2 - k1;
		r0 = 0;
		if (sum != 0) begin
			den = sum * sum;
			r0 = (diff * diff * UNIT + den / 2) / den;
		end
		o.tir = 1'b0;
		// exact test on the Q.15 cosine, only inside the unit range
		if (k1 > k2 && cq > -UNIT && cq < UNIT) begin
			s = (64'sd1 <<< 30) - cq * cq;
			if (k1 * k1 * s > ((k2 * k2) <<< 30))
				o.tir = 1'b1;
		end
		if (o.tir) begin
			res = UNIT;
		end else begin
			x = UNIT - cq;
			if (x >= UNIT) begin
				res = UNIT;
			end else begin
				ux = (x > 0) ? x : 0;
				p = ux;
				repeat (4) p = round_q15(p, ux);
				res = r0 + round_q15(UNIT - r0, p);
				if (res > UNIT)
					res = UNIT;
			end
		end
		o.frac = 16'(res);
		return o;
	endfunction

	task automatic add_row(int ix, int iy, int iz, int nx, int ny, int nz, int kf, int kt,
		bit preset, int frac, bit tir);
		dir_row_t r;
		r.hit = '{16'(ix), 16'(iy), 16'(iz), 16'(nx), 16'(ny), 16'(nz), 16'(kf), 16'(kt)};
		r.preset = preset;
		r.want = '{16'(frac), tir};
		dir_table.push_back(r);
	endtask

	// Sender gap: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [VecW-1:0] rand_comp(int span);
		return 16'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// Index in Q2.14: near 1.0 most of the time, extremes now and then
	function automatic logic [IdxW-1:0] rand_index();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 16'($urandom_range(16384, 32768));
		else if (r < 9)
			return 16'($urandom_range(16384, 65535));
		else
			return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h4000;
	endfunction

	function automatic hit_t random_hit();
		hit_t h;
		logic signed [VecW-1:0] iv[3];
		logic signed [VecW-1:0] nv[3];
		logic [IdxW-1:0] ka, kb;
		int mode, axis, order;
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			// unit normal on one axis, cosine swept across [-1, 1]
			axis = $urandom_range(0, 2);
			for (int i = 0; i < 3; i++) begin
				nv[i] = '0;
				iv[i] = rand_comp(16384);
			end
			nv[axis] = ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
		end else if (mode < 8) begin
			// short vectors, cosine near zero
			for (int i = 0; i < 3; i++) begin
				nv[i] = rand_comp(3000);
				iv[i] = rand_comp(3000);
			end
		end else begin
			// full-range noise
			for (int i = 0; i < 3; i++) begin
				nv[i] = 16'($urandom);
				iv[i] = 16'($urandom);
			end
		end
		ka = rand_index();
		kb = rand_index();
		order = $urandom_range(0, 9);
		h.ix = iv[0];
		h.iy = iv[1];
		h.iz = iv[2];
		h.nx = nv[0];
		h.ny = nv[1];
		h.nz = nv[2];
		if (order < 5) begin
			h.kf = (ka > kb) ? ka : kb;
			h.kt = (ka > kb) ? kb : ka;
		end else if (order < 8) begin
			h.kf = (ka > kb) ? kb : ka;
			h.kt = (ka > kb) ? ka : kb;
		end else begin
			h.kf = ka;
			h.kt = ka;
		end
		return h;
	endfunction

	// Present one hit, hold it until accepted, then queue its expected item
	task automatic drive_hit(hit_t h, shade_t want, bit no_gap);
		int gap;
		gap = no_gap ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		incident_x <= h.ix;
		incident_y <= h.iy;
		incident_z <= h.iz;
		normal_x <= h.nx;
		normal_y <= h.ny;
		normal_z <= h.nz;
		index_from <= h.kf;
		index_to <= h.kt;
		do @(posedge clk); while (!in_ready);
		reflect_due_q.push_back(want);
	endtask

	// Check returned items in order and pace the receiver
	always @(posedge clk) begin : sink
		shade_t want;
		int r;
		if (out_valid && out_ready) begin
			if (reflect_due_q.size() == 0) begin
				$error("unexpected item: reflect_fraction %0d total_internal %0d",
					reflect_fraction, total_internal);
				mismatch_count++;
			end else begin
				want = reflect_due_q.pop_front();
				if (reflect_fraction !== want.frac) begin
					$error("reflect_fraction: expected %0d, got %0d", want.frac,
						reflect_fraction);
					mismatch_count++;
				end
				if (total_internal !== want.tir) begin
					$error("total_internal: expected %0d, got %0d", want.tir,
						total_internal);
					mismatch_count++;
				end
			end
		end
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				out_ready <= 1'b1;
				ready_hold <= $urandom_range(0, 40);
			end else if (r < 92) begin
				out_ready <= 1'b0;
				ready_hold <= $urandom_range(0, 3);
			end else begin
				out_ready <= 1'b0;
				ready_hold <= $urandom_range(10, 40);
			end
		end
	end

	// Drop the run when no item moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin : stimulus
		dir_row_t row;
		hit_t h;
		shade_t want;
		// normal incidence, matched indices: nothing reflects
		add_row(0, 0, -16384, 0, 0, 16384, 16384, 16384, PRESET, 0, 1'b0);
		// grazing, matched indices: saturates
		add_row(16384, 0, 0, 0, 0, 16384, 16384, 16384, PRESET, OneQ15, 1'b0);
		// grazing from the denser medium: total internal reflection
		add_row(16384, 0, 0, 0, 0, 16384, 32768, 16384, PRESET, OneQ15, 1'b1);
		// cosine exactly minus one: no total internal reflection, saturates
		add_row(0, 0, 16384, 0, 0, 16384, 65535, 16384, PRESET, OneQ15, 1'b0);
		// cosine exactly one, denser medium: plain r0
		add_row(0, 0, -16384, 0, 0, 16384, 65535, 16384, CALC, 0, 1'b0);
		// cosine far above one, matched indices: zero
		add_row(32767, 32767, 32767, -32768, -32768, -32768, 65535, 65535, PRESET, 0, 1'b0);
		// cosine far above one, mismatched indices: r0 only
		add_row(32767, 32767, 32767, -32768, -32768, -32768, 65535, 16384, CALC, 0, 1'b0);
		// most negative cosine: saturates, no total internal reflection
		add_row(-32768, -32768, -32768, -32768, -32768, -32768, 65535, 16384,
			PRESET, OneQ15, 1'b0);
		add_row(-32768, -32768, -32768, 32767, 32767, 32767, 16384, 65535, CALC, 0, 1'b0);
		// cosine just below one
		add_row(0, 0, -16383, 0, 0, 16384, 65535, 16384, CALC, 0, 1'b0);
		// either side of the critical angle for a 1.5 to 1.0 interface
		add_row(0, 0, -12200, 0, 0, 16384, 24576, 16384, CALC, 0, 1'b0);
		add_row(0, 0, -12220, 0, 0, 16384, 24576, 16384, CALC, 0, 1'b0);
		add_row(5000, -7000, -9000, 1000, 2000, 15000, 20000, 18000, CALC, 0, 1'b0);
		// grazing into the denser medium: saturates without the flag
		add_row(16384, 0, 0, 0, 0, 16384, 16384, 65535, PRESET, OneQ15, 1'b0);
		// cosine one step below zero, denser medium: total internal reflection
		add_row(0, 0, 1, 0, 0, 1, 32768, 16384, PRESET, OneQ15, 1'b1);
		// cosine rounds down to zero: saturates
		add_row(0, 0, -1, 0, 0, 1, 16384, 16384, PRESET, OneQ15, 1'b0);
		add_row(-21846, 10923, -5462, 12345, -23456, 30000, 40000, 50000, CALC, 0, 1'b0);
		add_row(-12000, 3000, -9000, 16384, 0, 0, 65535, 65535, CALC, 0, 1'b0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (dir_table[i]) begin
			row = dir_table[i];
			want = row.preset ? row.want : schlick_reflectance(row.hit);
			drive_hit(row.hit, want, 1'b0);
		end

		// random hits, with one full drain on the way
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == DRAIN_AT) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (reflect_due_q.size() != 0);
			end
			h = random_hit();
			drive_hit(h, schlick_reflectance(h), n >= BURST_LO && n < BURST_HI);
		end

		// wait out every result, then let the pipeline settle
		in_valid <= 1'b0;
		do @(posedge clk); while (reflect_due_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && reflect_due_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
